>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of an implication on clk, muted while reset is low.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Concurrent check of a next-cycle implication on clk, muted while reset is low.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sha512_pkg.sv
package sha512_pkg;

  typedef logic [63:0] word_t;

  typedef struct packed {
    word_t      data;
    logic [3:0] nbytes;
    logic       last;
  } beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } core_state_t;

  localparam word_t INIT_H [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage

>>> rtl/sha512_hash_engine.sv
// The core takes a beat while idle and unpacks it one byte per cycle; each full block
// then runs the compression rounds and a hash update before unpacking resumes.
// A last beat adds the 0x80 pad byte and zero bytes at one per cycle, a length step
// and one or two compressions before its digest beats are offered.
// A two-entry queue in front of the core holds up to two beats while the core works.
// Synchronous active-low reset restores the initial hash values and clears counts.
module sha512_hash_engine #(
  parameter int QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha512_pkg::*;

  beat_t wr_beat, rd_beat;
  logic  rd_valid, rd_ready;

  assign wr_beat = '{data: in_data_word, nbytes: in_valid_bytes, last: in_last};

  sha512_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n,
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_beat,
    .rd_valid, .rd_ready, .rd_beat
  );

  sha512_core u_core (
    .clk, .rst_n,
    .in_valid(rd_valid), .in_ready(rd_ready), .in_beat(rd_beat),
    .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_last_word
  );
endmodule

>>> rtl/sha512_queue.sv
module sha512_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  sha512_pkg::beat_t   wr_beat,
  output logic                rd_valid,
  input  logic                rd_ready,
  output sha512_pkg::beat_t   rd_beat
);
  import sha512_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  beat_t          slot_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           push, pop;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_beat  = slot_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= wr_beat;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

>>> rtl/sha512_core.sv
module sha512_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sha512_pkg::beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last_word
);
  import sha512_pkg::*;

  core_state_t state_r, state_nxt;

  word_t       h_r [8];
  word_t       v_r [8];
  word_t       w_r [16];
  logic [6:0]  pos_r;
  logic [127:0] bits_r;
  logic [6:0]  rnd_r;
  logic        fin_r;
  logic        pad_done_r;
  logic        len_pend_r;
  word_t       cur_r;
  logic [3:0]  left_r;
  logic [2:0]  oidx_r;

  logic        take, byte_go, blk_full;
  logic [7:0]  byte_v;
  logic [3:0]  idx;
  logic [5:0]  sh;
  word_t       t1, t2, s0, s1, wnew, big0, big1, ch, mj;
  logic [3:0]  nb;

  assign nb       = (in_beat.nbytes > 4'd8) ? 4'd8 : in_beat.nbytes;
  assign in_ready = (state_r == ST_IDLE);
  assign take     = in_valid && in_ready;
  assign idx      = pos_r[6:3];
  assign sh       = 6'd56 - {pos_r[2:0], 3'b000};

  always_comb begin
    byte_go = 1'b0;
    byte_v  = 8'h00;
    if (state_r == ST_FILL) begin
      if (left_r != 4'd0) begin
        byte_go = 1'b1;
        byte_v  = cur_r[63:56];
      end else if (fin_r && !pad_done_r) begin
        byte_go = 1'b1;
        byte_v  = 8'h80;
      end else if (fin_r && len_pend_r && pos_r != 7'd112) begin
        byte_go = 1'b1;
      end
    end
  end
  assign blk_full = byte_go && (pos_r == 7'd127);

  always_comb begin
    big1 = rotr(v_r[4], 14) ^ rotr(v_r[4], 18) ^ rotr(v_r[4], 41);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + big1 + ch + ROUND_K[rnd_r] + w_r[0];
    big0 = rotr(v_r[0], 28) ^ rotr(v_r[0], 34) ^ rotr(v_r[0], 39);
    mj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = big0 + mj;
    s0   = rotr(w_r[1], 1) ^ rotr(w_r[1], 8) ^ (w_r[1] >> 7);
    s1   = rotr(w_r[14], 19) ^ rotr(w_r[14], 61) ^ (w_r[14] >> 6);
    wnew = s1 + w_r[9] + s0 + w_r[0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (take) state_nxt = ST_FILL;
      ST_FILL: begin
        if (blk_full) state_nxt = ST_ROUND;
        else if (!byte_go) begin
          if (fin_r && len_pend_r) state_nxt = ST_ROUND;
          else if (fin_r) state_nxt = ST_EMIT;
          else state_nxt = ST_IDLE;
        end
      end
      ST_ROUND:  if (rnd_r == 7'd79) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = (fin_r && !len_pend_r && left_r == 4'd0 && pad_done_r &&
                              pos_r == 7'd0) ? ST_EMIT : ST_FILL;
      ST_EMIT:   if (out_ready && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid       = (state_r == ST_EMIT);
    out_digest_word = h_r[oidx_r];
    out_word_index  = oidx_r;
    out_last_word   = (oidx_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
      pos_r      <= '0;
      bits_r     <= '0;
      rnd_r      <= '0;
      fin_r      <= 1'b0;
      pad_done_r <= 1'b0;
      len_pend_r <= 1'b0;
      left_r     <= '0;
      oidx_r     <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: if (take) begin
          cur_r      <= in_beat.data;
          left_r     <= nb;
          fin_r      <= in_beat.last;
          pad_done_r <= 1'b0;
          len_pend_r <= in_beat.last;
          bits_r     <= bits_r + {121'd0, nb, 3'b000};
        end
        ST_FILL: begin
          if (byte_go) begin
            if (pos_r[2:0] == 3'd0) w_r[idx] <= {byte_v, 56'd0};
            else w_r[idx] <= w_r[idx] | (word_t'(byte_v) << sh);
            pos_r <= pos_r + 7'd1;
            if (left_r != 4'd0) begin
              left_r <= left_r - 4'd1;
              cur_r  <= cur_r << 8;
            end else if (fin_r && !pad_done_r) pad_done_r <= 1'b1;
          end else if (fin_r && len_pend_r) begin
            w_r[14]    <= bits_r[127:64];
            w_r[15]    <= bits_r[63:0];
            len_pend_r <= 1'b0;
            pos_r      <= 7'd0;
          end
          if (state_nxt == ST_ROUND) begin
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
            rnd_r <= '0;
          end
        end
        ST_ROUND: begin
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          rnd_r   <= rnd_r + 7'd1;
        end
        ST_UPDATE: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        end
        ST_EMIT: if (out_ready) begin
          oidx_r <= oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
            pos_r  <= '0;
            bits_r <= '0;
            fin_r  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/sha512_checker.sv
`include "assert_macros.svh"
module sha512_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);
  `CHK_IMPL(a_last_idx, out_valid, out_last_word == (out_word_index == 3'd7), "last_word mismatch")
  `CHK_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_digest_word), "stall lost")
  `CHK_NEXT(a_seq, out_valid && out_ready && !out_last_word, out_valid, "digest gap")
  `CHK_NEXT(a_inc, out_valid && out_ready && !out_last_word, out_word_index == $past(out_word_index) + 3'd1, "index skip")
endmodule

bind sha512_hash_engine sha512_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_last_word
);

>>> tb/sv/tb_sha512_hash_engine.sv
module tb_sha512_hash_engine;
  import sha512_pkg::*;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
  } stim_t;

  typedef struct {
    logic [63:0] digest;
    logic [2:0]  index;
    logic        last_word;
  } digest_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_data_word;
  logic [3:0]  in_valid_bytes;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha512_hash_engine i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digest_word(out_digest_word),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };
  localparam logic [63:0] K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  logic [63:0]   chain [8];
  logic [63:0]   blk [16];
  int unsigned   fill;
  logic [127:0]  bit_len;
  digest_beat_t  digest_q [$];
  stim_t         dir_tab [$];
  int            errors;
  int            n_words;
  int            n_digests;
  int            n_checked;
  bit            quiet;
  bit            hold_rx;

  function automatic logic [63:0] ror(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = blk[t];
    for (int t = 16; t < 80; t++) begin
      s0 = ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7);
      s1 = ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int t = 0; t < 8; t++) v[t] = chain[t];
    for (int t = 0; t < 80; t++) begin
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[t] + w[t];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int t = 0; t < 8; t++) chain[t] += v[t];
  endtask

  task automatic push_byte(logic [7:0] b);
    int unsigned idx;
    idx = fill >> 3;
    if ((fill & 7) == 0) blk[idx] = '0;
    blk[idx] |= 64'(b) << (56 - 8 * (fill & 7));
    fill++;
    if (fill == 128) begin
      compress();
      fill = 0;
    end
  endtask

  task automatic hash_init();
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    for (int i = 0; i < 16; i++) blk[i] = '0;
    fill = 0;
    bit_len = '0;
  endtask

  task automatic absorb_word(stim_t s);
    int unsigned n;
    digest_beat_t d;
    n = (s.nbytes > 8) ? 8 : s.nbytes;
    bit_len += 128'(n * 8);
    for (int i = 0; i < n; i++) push_byte(s.data[63 - 8*i -: 8]);
    if (s.last) begin
      push_byte(8'h80);
      if (fill > 112 || fill == 0) begin
        if (fill > 112) while (fill != 0) push_byte(8'h00);
      end
      while (fill != 112) push_byte(8'h00);
      blk[14] = bit_len[127:64];
      blk[15] = bit_len[63:0];
      compress();
      for (int i = 0; i < 8; i++) begin
        d.digest = chain[i];
        d.index = 3'(i);
        d.last_word = (i == 7);
        digest_q.push_back(d);
      end
      n_digests++;
      hash_init();
    end
  endtask

  task automatic send_word(stim_t s);
    if (!quiet) begin
      while ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data_word <= s.data;
    in_valid_bytes <= s.nbytes;
    in_last <= s.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_word(s);
    n_words++;
  endtask

  function automatic stim_t mk(logic [63:0] d, logic [3:0] n, logic l);
    stim_t s;
    s.data = d; s.nbytes = n; s.last = l;
    return s;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_rx) begin
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    digest_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest beat %h", $time, out_digest_word);
        errors++;
      end else begin
        e = digest_q.pop_front();
        n_checked++;
        if (out_digest_word !== e.digest || out_word_index !== e.index ||
            out_last_word !== e.last_word) begin
          $display("%0t: mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                   e.digest, e.index, e.last_word,
                   out_digest_word, out_word_index, out_last_word);
          errors++;
        end
      end
    end
  end

  initial begin
    int len;
    int wait_cyc;
    stim_t s;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_word = '0;
    in_valid_bytes = 4'd8;
    in_last = 1'b0;
    errors = 0; n_words = 0; n_digests = 0; n_checked = 0;
    quiet = 1'b0; hold_rx = 1'b0;
    hash_init();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: "abc", empty message, extremes, over-range counts, zero-byte ends,
    // unaligned packing and a 120-byte message past the 112-byte padding boundary.
    dir_tab.push_back(mk(64'h6162630000000000, 4'd3, 1'b1));
    dir_tab.push_back(mk(64'h0, 4'd0, 1'b1));
    dir_tab.push_back(mk('1, 4'd8, 1'b1));
    dir_tab.push_back(mk('1, 4'd15, 1'b0));
    dir_tab.push_back(mk(64'h0, 4'd9, 1'b1));
    dir_tab.push_back(mk(64'h0123456789abcdef, 4'd1, 1'b0));
    dir_tab.push_back(mk(64'hfedcba9876543210, 4'd7, 1'b0));
    dir_tab.push_back(mk('1, 4'd0, 1'b1));
    for (int i = 0; i < 14; i++) dir_tab.push_back(mk(rnd64(), 4'd8, 1'b0));
    dir_tab.push_back(mk(rnd64(), 4'd8, 1'b1));
    foreach (dir_tab[i]) send_word(dir_tab[i]);

    // The receiver stalls while messages keep coming.
    hold_rx = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_rx = 1'b0;
      end
      begin
        for (int m = 0; m < 3; m++) begin
          send_word(mk(rnd64(), 4'($urandom_range(0, 15)), 1'b0));
          send_word(mk(rnd64(), 4'($urandom_range(0, 15)), 1'b1));
        end
      end
    join

    while (n_words < 330) begin
      if (n_words > 290) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(14, 34);
      else len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        s = mk(rnd64(), ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'd8,
               1'b0);
        send_word(s);
      end
      s = mk(rnd64(), 4'($urandom_range(0, 15)), 1'b1);
      send_word(s);
    end
    in_valid <= 1'b0;

    wait_cyc = 0;
    while (digest_q.size() != 0 && wait_cyc < 100000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (200) @(posedge clk);
    $display("Fed %0d message words forming %0d messages; %0d digest beats checked.",
             n_words, n_digests, n_checked);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
